// ===== rtl/core/cprs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprs_pkg: shared types and constants
// frame and slot sizes, function codes, status codes, sequencer states
// ----------------------------------------------------------------------------
package cprs_pkg;

  localparam int NumFrames = 256;
  localparam int NumSlots  = 1024;
  localparam int FrameW    = 8;
  localparam int SlotW     = 10;
  localparam int CountW    = 9;
  localparam int WordW     = 32;
  localparam int NumWords  = NumSlots / WordW;
  localparam int WordIdxW  = $clog2(NumWords);
  localparam int BitIdxW   = $clog2(WordW);

  typedef enum logic [2:0] {
    FUNC_ADD   = 3'd0,
    FUNC_REM   = 3'd1,
    FUNC_TOUCH = 3'd2,
    FUNC_EVICT = 3'd3,
    FUNC_FREE  = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NO_SLOT  = 2'd2,
    ST_BAD_SLOT = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLEAR,
    S_DECODE,
    S_UL_RD,
    S_UL_WAIT,
    S_UL_WR,
    S_LT_RD,
    S_LT_WAIT,
    S_LT_WR,
    S_LT_OWN,
    S_EV_CHK,
    S_EV_RD,
    S_EV_WAIT,
    S_SL_RD,
    S_SL_WAIT,
    S_SL_CHK,
    S_SL_WR,
    S_FR_RD,
    S_FR_WAIT,
    S_FR_WR,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]        func;
    logic [FrameW-1:0] frame;
    logic [SlotW-1:0]  slot;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [FrameW-1:0] victim_frame;
    logic [SlotW-1:0]  swap_slot;
    logic [CountW-1:0] list_count;
  } rsp_t;

  // slot bitmap access from the sequencer
  typedef struct packed {
    logic                wr;
    logic [WordIdxW-1:0] addr;
    logic [WordW-1:0]    wdata;
  } slot_cmd_t;

endpackage

// ===== rtl/core/cprs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprs_if: valid/ready channel
// carries one payload of type T per transfer
// ----------------------------------------------------------------------------
interface cprs_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/cprs_slot_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprs_slot_mem: swap slot bitmap
// one 32-bit word per access, registered read
// ----------------------------------------------------------------------------
module cprs_slot_mem (
  input  logic                          clk_i,
  input  cprs_pkg::slot_cmd_t           cmd_i,
  output logic [cprs_pkg::WordW-1:0]    rdata_o
);
  import cprs_pkg::*;

  logic [WordW-1:0] mem_q [NumWords];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[cmd_i.addr] <= cmd_i.wdata;
    end
    rdata_o <= mem_q[cmd_i.addr];
  end

endmodule

// ===== rtl/core/clock_page_replacer_with_swap_slots.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_page_replacer_with_swap_slots: second-chance replacer, slot bitmap
// ring of resident frames plus swap slot allocator under one sequencer
// ----------------------------------------------------------------------------
// usage:
//   in_i carries func, frame, slot; out_o carries status, victim_frame,
//   swap_slot and list_count, one result per input transfer
//   the block takes one item at a time; in_i.ready is high only in idle
// steps per item, after the idle state that takes the transfer:
//   touch, remove of unlisted frame, evict on empty list, ignored codes:
//   straight to the result; remove: unlink; add: link at the tail, as a
//   ring of one onto an empty list, unlinked first when already listed
//   free slot: read-modify-write of one bitmap word
//   evict: skip referenced frames, clearing the ref bit (link memory read),
//   then search the bitmap one 32-slot word at a time and unlink the victim;
//   with no free slot the status is ST_NO_SLOT and the victim stays listed
//   the link memories and the bitmap each have one port
// reset:
//   on_list and ref bits are flip-flops cleared at once; after reset the
//   sequencer sweeps the 32-word slot bitmap to zero with in_i.ready low
// stall:
//   the result waits in the output register until out_o.ready; the next
//   item is processed meanwhile and waits in the last state for the
//   output register to free up
// ----------------------------------------------------------------------------
module clock_page_replacer_with_swap_slots (
  input  logic clk_i,
  input  logic rst_ni,
  cprs_if.sink   in_i,
  cprs_if.source out_o
);
  import cprs_pkg::*;

  state_e state_q, state_d;

  logic [FrameW-1:0] nxt_mem [NumFrames];
  logic [FrameW-1:0] prv_mem [NumFrames];
  logic [NumFrames-1:0] on_list_q, ref_q;
  logic [FrameW-1:0] head_q;
  logic [CountW-1:0] count_q;

  req_t req_q;
  rsp_t res_q;                       // result being built
  rsp_t rsp_q;                       // result offered on out_o
  logic rsp_valid_q;

  // link memory ports: one read address, one write per memory per cycle
  logic [FrameW-1:0] rd_addr;
  logic [FrameW-1:0] nxt_rd_q, prv_rd_q;
  logic [WordIdxW-1:0] widx_q;
  logic [WordW-1:0] sl_rdata;
  slot_cmd_t sl_cmd;
  logic [BitIdxW-1:0] free_bit;
  logic free_any;
  logic is_add;
  logic slot_bad;
  logic out_load;

  assign is_add   = (req_q.func == FUNC_ADD);
  assign slot_bad = ({1'b0, req_q.slot} >= (SlotW + 1)'(NumSlots));
  assign out_load = (state_q == S_OUT) && (!rsp_valid_q || out_o.ready);

  cprs_slot_mem u_slot_mem (
    .clk_i   (clk_i),
    .cmd_i   (sl_cmd),
    .rdata_o (sl_rdata)
  );

  // lowest clear bit in the fetched word
  always_comb begin
    free_bit = '0;
    free_any = 1'b0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (!sl_rdata[i]) begin
        free_bit = BitIdxW'(i);
        free_any = 1'b1;
      end
    end
  end

  // the unlinked frame's links must stay addressed until they are used
  always_comb begin
    case (state_q)
      S_UL_RD, S_UL_WAIT: rd_addr = req_q.frame;
      S_LT_RD:            rd_addr = head_q;
      default:            rd_addr = head_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    nxt_rd_q <= nxt_mem[rd_addr];
    prv_rd_q <= prv_mem[rd_addr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_i.valid) state_d = S_DECODE;
      S_CLEAR:  if (widx_q == WordIdxW'(NumWords - 1)) state_d = S_IDLE;
      S_DECODE: begin
        case (req_q.func)
          FUNC_ADD, FUNC_REM:
            state_d = on_list_q[req_q.frame] ? S_UL_RD :
                      (is_add ? S_LT_RD : S_OUT);
          FUNC_EVICT: state_d = (count_q == '0) ? S_OUT : S_EV_CHK;
          FUNC_FREE:  state_d = slot_bad ? S_OUT : S_FR_RD;
          default:    state_d = S_OUT;
        endcase
      end
      S_UL_RD:   state_d = S_UL_WAIT;
      S_UL_WAIT: state_d = S_UL_WR;
      S_UL_WR:   state_d = is_add ? S_LT_RD : S_OUT;
      S_LT_RD:   state_d = S_LT_WAIT;
      S_LT_WAIT: state_d = S_LT_WR;
      S_LT_WR:   state_d = (count_q == '0) ? S_OUT : S_LT_OWN;
      S_LT_OWN:  state_d = S_OUT;
      S_EV_CHK:  state_d = ref_q[head_q] ? S_EV_RD : S_SL_RD;
      S_EV_RD:   state_d = S_EV_WAIT;
      S_EV_WAIT: state_d = S_EV_CHK;
      S_SL_RD:   state_d = S_SL_WAIT;
      S_SL_WAIT: state_d = S_SL_CHK;
      S_SL_CHK: begin
        if (free_any) state_d = S_SL_WR;
        else if (widx_q == WordIdxW'(NumWords - 1)) state_d = S_OUT;
        else state_d = S_SL_RD;
      end
      S_SL_WR:   state_d = S_UL_RD;
      S_FR_RD:   state_d = S_FR_WAIT;
      S_FR_WAIT: state_d = S_FR_WR;
      S_FR_WR:   state_d = S_OUT;
      S_OUT:     if (!rsp_valid_q || out_o.ready) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // bitmap commands
  always_comb begin
    sl_cmd = '{wr: 1'b0, addr: widx_q, wdata: sl_rdata};
    case (state_q)
      S_CLEAR: begin
        sl_cmd.wr    = 1'b1;
        sl_cmd.wdata = '0;
      end
      S_SL_WR: begin
        sl_cmd.wr = 1'b1;
        sl_cmd.wdata[res_q.swap_slot[BitIdxW-1:0]] = 1'b1;
      end
      S_FR_RD, S_FR_WAIT: sl_cmd.addr = req_q.slot[SlotW-1:BitIdxW];
      S_FR_WR: begin
        sl_cmd.addr = req_q.slot[SlotW-1:BitIdxW];
        sl_cmd.wr   = 1'b1;
        sl_cmd.wdata[req_q.slot[BitIdxW-1:0]] = 1'b0;
      end
      default: ;
    endcase
  end

  // link memory writes
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_UL_WR: begin
        // unlink req_q.frame using its links read in S_UL_RD
        if (nxt_rd_q != req_q.frame) begin
          nxt_mem[prv_rd_q] <= nxt_rd_q;
          prv_mem[nxt_rd_q] <= prv_rd_q;
        end
      end
      S_LT_WR: begin
        if (count_q == '0) begin
          nxt_mem[req_q.frame] <= req_q.frame;
          prv_mem[req_q.frame] <= req_q.frame;
        end else begin
          // old tail and new frame point at each other
          nxt_mem[prv_rd_q]    <= req_q.frame;
          prv_mem[req_q.frame] <= prv_rd_q;
        end
      end
      S_LT_OWN: begin
        // new frame and head close the ring
        nxt_mem[req_q.frame] <= head_q;
        prv_mem[head_q]      <= req_q.frame;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      on_list_q   <= '0;
      ref_q       <= '0;
      head_q      <= '0;
      count_q     <= '0;
      widx_q      <= '0;
      req_q       <= '0;
      res_q       <= '0;
      rsp_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        rsp_valid_q <= 1'b1;
        rsp_q <= '{status: res_q.status, victim_frame: res_q.victim_frame,
                   swap_slot: res_q.swap_slot, list_count: count_q};
      end else if (out_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: widx_q <= widx_q + 1'b1;
        S_IDLE: if (in_i.valid) begin
          req_q <= in_i.data;
          res_q <= '0;
          widx_q <= '0;
        end
        S_DECODE: begin
          if (req_q.func == FUNC_TOUCH) ref_q[req_q.frame] <= 1'b1;
          if (req_q.func == FUNC_EVICT && count_q == '0) res_q.status <= ST_EMPTY;
          if (req_q.func == FUNC_FREE && slot_bad) res_q.status <= ST_BAD_SLOT;
        end
        S_UL_WR: begin
          if (nxt_rd_q == req_q.frame) head_q <= '0;
          else if (head_q == req_q.frame) head_q <= nxt_rd_q;
          on_list_q[req_q.frame] <= 1'b0;
          count_q <= count_q - 1'b1;
        end
        S_LT_WR: begin
          if (count_q == '0) head_q <= req_q.frame;
          on_list_q[req_q.frame] <= 1'b1;
          ref_q[req_q.frame]     <= 1'b0;
          count_q <= count_q + 1'b1;
        end
        S_EV_CHK: if (ref_q[head_q]) ref_q[head_q] <= 1'b0;
        S_EV_WAIT: head_q <= nxt_rd_q;
        S_SL_CHK: begin
          if (free_any) begin
            res_q.swap_slot    <= {widx_q, free_bit};
            res_q.victim_frame <= head_q;
            req_q.frame        <= head_q;
          end else if (widx_q == WordIdxW'(NumWords - 1)) begin
            res_q.status <= ST_NO_SLOT;
          end else begin
            widx_q <= widx_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = rsp_valid_q;
  assign out_o.data  = rsp_q;

endmodule
